// ----- sv/rolling_percentile_threshold_gate_macros.svh -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate: assertion macros
// Shared concurrent assertion forms, sampled on clk and quiet while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ROLLING_PERCENTILE_THRESHOLD_GATE_MACROS_SVH
`define ROLLING_PERCENTILE_THRESHOLD_GATE_MACROS_SVH

// A condition that holds at every clock edge.
`define RPTG_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequent that holds in the same cycle as its antecedent.
`define RPTG_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that holds in the cycle after its antecedent.
`define RPTG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/rptg_pkg.sv -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate: package
// Shared constants, payload types and controller/datapath interface types.
// ---------------------------------------------------------------------------
package rptg_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int SLOT_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W        = $clog2(WINDOW_MAX + 1);
    localparam int WLEN_W       = 7;
    localparam int LEN_CMP_W    = (WLEN_W > CNT_W) ? WLEN_W : CNT_W;
    localparam int ADDR_W       = 2;
    localparam int DATA_W       = 32;

    localparam logic [WLEN_W-1:0] WLEN_RESET        = WLEN_W'(20);
    localparam logic [ADDR_W-1:0] REG_WINDOW_LENGTH = ADDR_W'(0);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] deviation;
        logic                           deviation_valid;
        logic signed [31:0]             asset_return;
        logic                           return_valid;
    } sample_t;

    typedef struct packed {
        logic               position;
        logic signed [31:0] strategy_return;
    } result_t;

    typedef struct packed {
        logic accept;
        logic issue;
        logic publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_issue;
        logic out_hold;
    } ctrl_status_t;

endpackage

// ----- sv/rptg_ram.sv -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate: generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module rptg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rptg_ctrl.sv -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate: controller
// Sequences acceptance, the window scan, the pipeline drain and the result.
// ---------------------------------------------------------------------------
module rptg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    output rptg_pkg::ctrl_cmd_t    cmd,
    input  rptg_pkg::ctrl_status_t status
);

    import rptg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        sample_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!status.out_hold)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/rptg_datapath.sv -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate: datapath
// Sample store, presence flags, window scan counters and the result register.
// ---------------------------------------------------------------------------
`include "rolling_percentile_threshold_gate_macros.svh"

module rptg_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [rptg_pkg::WLEN_W-1:0]  window_length,
    input  rptg_pkg::sample_t            sample,
    input  rptg_pkg::ctrl_cmd_t          cmd,
    output rptg_pkg::ctrl_status_t       status,
    output logic                         result_valid,
    input  logic                         result_stall,
    output rptg_pkg::result_t            result
);

    import rptg_pkg::*;

    localparam logic [SAMPLE_WIDTH-1:0] SIGN_BIT = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic [SLOT_W-1:0]       newest_reg;
    logic [SLOT_W-1:0]       newest_next;
    logic [SLOT_W-1:0]       slot_inc;
    logic [WINDOW_MAX-1:0]   present_reg;
    logic [SLOT_W-1:0]       scan_reg;
    logic [SLOT_W:0]         rd_wrap;
    logic [SLOT_W-1:0]       rd_slot;
    logic                    pend_reg;
    logic                    pend_flag_reg;
    logic [CNT_W-1:0]        counted_reg;
    logic [CNT_W-1:0]        below_reg;
    logic [SAMPLE_WIDTH-1:0] cur_key_reg;
    logic [SAMPLE_WIDTH-1:0] in_key;
    logic                    cur_valid_reg;
    logic signed [31:0]      ret_reg;
    logic                    ret_valid_reg;
    logic [SAMPLE_WIDTH-1:0] ram_q;
    logic [LEN_CMP_W-1:0]    wl_wide;
    logic [CNT_W-1:0]        eff_len;
    logic [CNT_W+1:0]        rank3;
    logic [CNT_W-1:0]        rank;
    logic                    position;
    logic                    result_valid_reg;
    logic                    result_valid_next;
    result_t                 result_reg;

    assign in_key   = sample.deviation ^ SIGN_BIT;
    assign slot_inc = (newest_reg == SLOT_W'(WINDOW_MAX - 1)) ? '0 : newest_reg + 1'b1;
    assign newest_next = cmd.accept ? slot_inc : newest_reg;

    always_comb
    begin
        wl_wide = LEN_CMP_W'(window_length);
        if (wl_wide == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (wl_wide > LEN_CMP_W'(WINDOW_MAX))
        begin
            eff_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = CNT_W'(wl_wide);
        end
    end

    assign rd_wrap = (scan_reg > newest_reg)
                   ? {1'b0, newest_reg} + (SLOT_W+1)'(WINDOW_MAX) - {1'b0, scan_reg}
                   : {1'b0, newest_reg} - {1'b0, scan_reg};
    assign rd_slot = rd_wrap[SLOT_W-1:0];

    assign status.last_issue = (CNT_W'(scan_reg) == eff_len - 1'b1);
    assign status.out_hold   = result_valid_reg && result_stall;

    rptg_ram #(
        .WIDTH(SAMPLE_WIDTH),
        .DEPTH(WINDOW_MAX)
    ) u_store (
        .clk  (clk),
        .we   (cmd.accept),
        .waddr(slot_inc),
        .wdata(sample.deviation_valid ? in_key : '0),
        .raddr(rd_slot),
        .rdata(ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            newest_reg       <= SLOT_W'(WINDOW_MAX - 1);
            present_reg      <= '0;
            scan_reg         <= '0;
            pend_reg         <= 1'b0;
            counted_reg      <= '0;
            below_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            newest_reg       <= newest_next;
            pend_reg         <= cmd.issue;
            result_valid_reg <= result_valid_next;
            if (cmd.accept)
            begin
                present_reg[slot_inc] <= sample.deviation_valid;
                scan_reg              <= '0;
                counted_reg           <= '0;
                below_reg             <= '0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    scan_reg <= scan_reg + 1'b1;
                end
                if (pend_reg && pend_flag_reg)
                begin
                    counted_reg <= counted_reg + 1'b1;
                    if (ram_q < cur_key_reg)
                    begin
                        below_reg <= below_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_flag_reg <= present_reg[rd_slot];
        if (cmd.accept)
        begin
            cur_key_reg   <= in_key;
            cur_valid_reg <= sample.deviation_valid;
            ret_reg       <= sample.asset_return;
            ret_valid_reg <= sample.return_valid;
        end
        if (cmd.publish)
        begin
            result_reg.position        <= position;
            result_reg.strategy_return <= (position && ret_valid_reg) ? ret_reg : '0;
        end
    end

    assign rank3    = ({2'b00, counted_reg} << 1) + {2'b00, counted_reg} + (CNT_W+2)'(3);
    assign rank     = rank3[CNT_W+1:2];
    assign position = cur_valid_reg && (counted_reg != '0) && (below_reg >= rank);

    assign result_valid_next = cmd.publish || (result_valid_reg && result_stall);
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

    `RPTG_ASSERT(a_below_le_counted, below_reg <= counted_reg, "below count exceeds counted samples")
    `RPTG_ASSERT_IMP(a_counted_in_window, cmd.publish, counted_reg <= eff_len, "counted beyond window")
    `RPTG_ASSERT_NEXT(a_invalid_flat, cmd.publish && !cur_valid_reg, !result_reg.position, "invalid sample went long")
    `RPTG_ASSERT_IMP(a_flat_zero, result_valid_reg && !result_reg.position, result_reg.strategy_return == '0, "flat result carries a return")

endmodule

// ----- sv/rolling_percentile_threshold_gate.sv -----
// ---------------------------------------------------------------------------
// Rolling percentile threshold gate
// Gates an asset return on a deviation sample beating its window 75th percentile.
// ---------------------------------------------------------------------------
// The sample channel (sample_valid, sample_stall, sample) carries one deviation
// and one asset return per transfer; the result channel (result_valid,
// result_stall, result) returns one position and gated return per sample.
// After a sample transfer the block scans the window held in its sample store,
// one slot per cycle through the RAM read port, where the window is the
// effective window_length W (clamped to 1..64). The result is presented after
// the scan and the drain and finish states, and the next sample is taken only
// once the block is back in idle; the store read port sets the pace.
// While the block works, sample_stall is high. A result waiting under
// result_stall holds its value; the following sample is still taken and
// scanned, and the block waits with its finished result until the result
// register is free. Reset clears the presence flags and result_valid, sets
// the write pointer to the last slot and window_length to 20; no clearing
// pass is needed. The window_length register lies at byte address 0 of the APB
// port; the user must write it only while idle, which the block does not check.
// ---------------------------------------------------------------------------
module rolling_percentile_threshold_gate (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  rptg_pkg::sample_t            sample,
    output logic                         result_valid,
    input  logic                         result_stall,
    output rptg_pkg::result_t            result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rptg_pkg::ADDR_W-1:0]  paddr,
    input  logic [rptg_pkg::DATA_W-1:0]  pwdata,
    output logic [rptg_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    import rptg_pkg::*;

    logic [WLEN_W-1:0] window_length_reg;
    logic [WLEN_W-1:0] window_length_next;
    logic [ADDR_W-1:0] reg_index;
    logic              cfg_write;
    ctrl_cmd_t         cmd;
    ctrl_status_t      status;

    assign pready    = 1'b1;
    assign reg_index = paddr >> 2;
    assign cfg_write = psel && penable && pwrite && pready;

    assign window_length_next = (cfg_write && (reg_index == REG_WINDOW_LENGTH))
                              ? pwdata[WLEN_W-1:0] : window_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WLEN_RESET;
        end
        else
        begin
            window_length_reg <= window_length_next;
        end
    end

    assign prdata = (reg_index == REG_WINDOW_LENGTH) ? DATA_W'(window_length_reg) : '0;

    rptg_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .cmd         (cmd),
        .status      (status)
    );

    rptg_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_length(window_length_reg),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
